// File: rtl/sghold_pkg.sv
// ============================================================================
// sghold_pkg - shared types and constants for the silence gate
// Sample width, stream widths, register map and the event code.
// ============================================================================
package sghold_pkg;

  // Sample and derived widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int MAG_W        = SAMPLE_WIDTH + 1;
  localparam int THR_W        = 16;
  localparam int CMP_W        = (MAG_W > THR_W) ? MAG_W : THR_W;
  localparam int TIME_W       = 32;

  // Stream payload widths, padded to whole bytes
  localparam int S_DATA_W = ((SAMPLE_WIDTH + TIME_W + 7) / 8) * 8;
  localparam int M_DATA_W = 8;

  // APB port widths
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (address bits [3:2])
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_THRESH  = 2'd1;
  localparam logic [1:0] REG_HOLD    = 2'd2;

  // Register reset values
  localparam logic             ENABLED_RST = 1'b1;
  localparam logic [THR_W-1:0]  THRESH_RST  = THR_W'(328);
  localparam logic [TIME_W-1:0] HOLD_RST    = TIME_W'(2000);

  // Event code carried with each result
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BEGAN = 2'd1,
    EV_ENDED = 2'd2
  } evt_t;

  // Settings handed from the register block to the detector
  typedef struct packed {
    logic              enabled;
    logic [THR_W-1:0]  loud_threshold;
    logic [TIME_W-1:0] hold_ms;
    logic              clear;
  } cfg_t;

endpackage

// File: rtl/sghold_cfg.sv
// ============================================================================
// sghold_cfg - configuration registers
// APB write/read of enabled, loud_threshold and hold_ms; any write of a
// listed register pulses a clear of the detection state.
// ============================================================================
module sghold_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sghold_pkg::ADDR_W-1:0] paddr,
  input  logic [sghold_pkg::DATA_W-1:0] pwdata,
  output logic [sghold_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sghold_pkg::cfg_t            cfg
);
  import sghold_pkg::*;

  logic              enabled;
  logic [THR_W-1:0]  loud_threshold;
  logic [TIME_W-1:0] hold_ms;
  logic              clear;
  logic              wr;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  // Hold register values; pulse clear on a write of a listed register
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= ENABLED_RST;
      loud_threshold <= THRESH_RST;
      hold_ms        <= HOLD_RST;
      clear          <= 1'b0;
    end else begin
      clear <= 1'b0;
      if (wr) begin
        case (idx)
          REG_ENABLED: begin
            enabled <= pwdata[0];
            clear   <= 1'b1;
          end
          REG_THRESH: begin
            loud_threshold <= pwdata[THR_W-1:0];
            clear          <= 1'b1;
          end
          REG_HOLD: begin
            hold_ms <= pwdata[TIME_W-1:0];
            clear   <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ENABLED: prdata = DATA_W'(enabled);
      REG_THRESH:  prdata = DATA_W'(loud_threshold);
      REG_HOLD:    prdata = DATA_W'(hold_ms);
      default:     prdata = '0;
    endcase
  end

  assign cfg.enabled        = enabled;
  assign cfg.loud_threshold = loud_threshold;
  assign cfg.hold_ms        = hold_ms;
  assign cfg.clear          = clear;

endmodule

// File: rtl/sghold_core.sv
// ============================================================================
// sghold_core - sample register, silence detector and result register
// One sample is registered, compared and folded into the detector state;
// a marked sample loads one result into the output register.
// ============================================================================
module sghold_core (
  input  logic                               clk,
  input  logic                               rst,
  input  sghold_pkg::cfg_t                   cfg,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [sghold_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                               in_last_sample,
  input  logic [sghold_pkg::TIME_W-1:0]      in_now,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic                               out_pass,
  output sghold_pkg::evt_t                   out_event
);
  import sghold_pkg::*;

  // Input register
  logic                           in_valid;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           last_q;
  logic [TIME_W-1:0]              now_q;

  // Detector state
  logic              loud_seen;
  logic [TIME_W-1:0] quiet_since;
  logic              quiet_valid;
  logic              in_silence;

  // Output register
  logic out_valid;
  logic pass_q;
  evt_t event_q;

  logic              consume;
  logic              finish;
  logic [MAG_W-1:0]  mag;
  logic              over;
  logic              loud;
  logic [TIME_W-1:0] elapsed;
  logic              loud_seen_next;
  logic [TIME_W-1:0] quiet_since_next;
  logic              quiet_valid_next;
  logic              in_silence_next;
  logic              pass_next;
  evt_t              event_next;

  // A plain sample always moves on; a marked one needs a free result slot
  assign consume  = in_valid && (!last_q || !out_valid || m_tready);
  assign finish   = consume && last_q;
  assign s_tready = !in_valid || consume;

  // Magnitude with the most negative value kept exact
  assign mag  = sample_q[SAMPLE_WIDTH-1]
              ? (MAG_W'(0) - {sample_q[SAMPLE_WIDTH-1], sample_q})
              : {1'b0, sample_q};
  assign over = CMP_W'(mag) > CMP_W'(cfg.loud_threshold);
  assign loud = loud_seen || over;
  assign elapsed = now_q - quiet_since;

  // Next detector state and result for the item in the input register
  always_comb begin
    loud_seen_next   = loud;
    quiet_since_next = quiet_since;
    quiet_valid_next = quiet_valid;
    in_silence_next  = in_silence;
    event_next       = EV_NONE;
    pass_next        = 1'b1;
    if (last_q) begin
      loud_seen_next = 1'b0;
      if (cfg.enabled) begin
        if (!loud) begin
          if (!quiet_valid) begin
            quiet_since_next = now_q;
            quiet_valid_next = 1'b1;
          end else if (elapsed >= cfg.hold_ms && !in_silence) begin
            in_silence_next = 1'b1;
            event_next      = EV_BEGAN;
          end
        end else begin
          if (in_silence) begin
            event_next = EV_ENDED;
          end
          in_silence_next  = 1'b0;
          quiet_since_next = '0;
          quiet_valid_next = 1'b0;
        end
        pass_next = !in_silence_next;
      end
    end
  end

  // Load samples into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample_q <= in_sample;
      last_q   <= in_last_sample;
      now_q    <= in_now;
    end
  end

  // Advance detector state; a register write clears detection
  always_ff @(posedge clk) begin
    if (rst) begin
      loud_seen   <= 1'b0;
      quiet_since <= '0;
      quiet_valid <= 1'b0;
      in_silence  <= 1'b0;
    end else begin
      if (consume) begin
        loud_seen   <= loud_seen_next;
        quiet_since <= quiet_since_next;
        quiet_valid <= quiet_valid_next;
        in_silence  <= in_silence_next;
      end
      if (cfg.clear) begin
        quiet_since <= '0;
        quiet_valid <= 1'b0;
        in_silence  <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pass_q  <= pass_next;
      event_q <= event_next;
    end
  end

  assign m_tvalid  = out_valid;
  assign out_pass  = pass_q;
  assign out_event = event_q;

  // Checks
  a_began_drops: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_q == EV_BEGAN |-> !pass_q)
    else $error("silence-began result passes its buffer");

  a_ended_passes: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_q == EV_ENDED |-> pass_q)
    else $error("silence-ended result drops its buffer");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cfg.clear |=> !in_silence && !quiet_valid)
    else $error("register write did not clear detection");

  a_rise_event: assert property (@(posedge clk) disable iff (rst)
    $rose(in_silence) |-> out_valid && event_q == EV_BEGAN)
    else $error("silence declared without a began result");

  a_fall_event: assert property (@(posedge clk) disable iff (rst)
    $fell(in_silence) && !$past(cfg.clear) |-> out_valid && event_q == EV_ENDED)
    else $error("silence left without an ended result");

endmodule

// File: rtl/silence_gate_with_hold_time_top.sv
// ============================================================================
// silence_gate_with_hold_time_top - audio squelch with hold time
// Marks each buffer loud or quiet, declares silence after hold_ms of quiet
// buffers and drops buffers while silent; reports began/ended events.
// ============================================================================
//
//  channel   direction  payload
//  s_*       in         sample, now_ms in tdata; last_in_buffer in tlast
//  m_*       out        pass_buffer, event_res in tdata (one per buffer)
//  APB       in/out     enabled @0x0, loud_threshold @0x4, hold_ms @0x8
//
//  One sample per cycle sustained while the result slot is free; a marked
//  sample's result is loaded into the output register as that sample
//  leaves the input register.
//  Reset (rst, synchronous) empties both registers and clears detection.
//  A stalled result holds the output register; plain samples keep flowing
//  and a marked sample waits in the input register until the slot frees.
//
module silence_gate_with_hold_time_top (
  input  logic                              clk,
  input  logic                              rst,
  // Sample stream: tdata = sample, now_ms (low bits first); tlast = last_in_buffer
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sghold_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic                              s_tlast,
  // Result stream: tdata = pass_buffer, event_res (low bits first), zero padded
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sghold_pkg::M_DATA_W-1:0]   m_tdata,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sghold_pkg::ADDR_W-1:0]     paddr,
  input  logic [sghold_pkg::DATA_W-1:0]     pwdata,
  output logic [sghold_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);
  import sghold_pkg::*;

  cfg_t cfg;
  logic out_pass;
  evt_t out_event;

  // Register block
  sghold_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Detector
  sghold_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .in_sample      (s_tdata[SAMPLE_WIDTH-1:0]),
    .in_last_sample (s_tlast),
    .in_now         (s_tdata[SAMPLE_WIDTH +: TIME_W]),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .out_pass       (out_pass),
    .out_event      (out_event)
  );

  // Pack the result
  assign m_tdata = {(M_DATA_W - 3)'(0), out_event, out_pass};

endmodule
